// ----- rtl/core/ppds_pkg.sv -----
// ----------------------------------------------------------------------------
// ppds_pkg
// shared constants and sequencer states for the point to polyline distance
// block
// ----------------------------------------------------------------------------
package ppds_pkg;

  localparam int COORD_BITS_DEF    = 24;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int DIST_BITS         = 50;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIFF,
    S_LEN_X,
    S_LEN_Y,
    S_DOT_X,
    S_DOT_Y,
    S_DOT_ADD,
    S_CHOOSE,
    S_DIV,
    S_AX,
    S_AY,
    S_PY,
    S_DIST_X,
    S_DIST_Y,
    S_DIST_ADD,
    S_UPDATE,
    S_FINISH
  } ppds_state_t;

endpackage

// ----- rtl/core/ppds_mul.sv -----
// ----------------------------------------------------------------------------
// ppds_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module ppds_mul
  import ppds_pkg::*;
#(
  parameter int WIDTH = 26
) (
  input  logic                      clk,
  input  logic signed [WIDTH-1:0]   a,
  input  logic signed [WIDTH-1:0]   b,
  output logic signed [2*WIDTH-1:0] p
);

  always_ff @(posedge clk) begin
    p <= (2*WIDTH)'(a) * (2*WIDTH)'(b);
  end

endmodule

// ----- rtl/core/ppds_div.sv -----
// ----------------------------------------------------------------------------
// ppds_div
// restoring fraction divider, one quotient bit per cycle, numer < denom
// ----------------------------------------------------------------------------
module ppds_div
  import ppds_pkg::*;
#(
  parameter int NUM_BITS      = 50,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NUM_BITS-1:0]      numer,
  input  logic [NUM_BITS-1:0]      denom,
  output logic                     busy,
  output logic [FRACTION_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic [NUM_BITS:0]     rem;
  logic [NUM_BITS-1:0]   den;
  logic [CNT_W-1:0]      count;
  logic [NUM_BITS:0]     shifted;
  logic                  take;

  always_comb begin
    shifted = {rem[NUM_BITS-1:0], 1'b0};
    take    = shifted >= (NUM_BITS+1)'(den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(FRACTION_BITS);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= (NUM_BITS+1)'(numer);
      den      <= denom;
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? shifted - (NUM_BITS+1)'(den) : shifted;
      quotient <= {quotient[FRACTION_BITS-2:0], take};
    end
  end

endmodule

// ----- rtl/core/point_polyline_distance_squared.sv -----
// ----------------------------------------------------------------------------
// point_polyline_distance_squared
// running minimum squared distance from a query point to a 2d polyline,
// vertices arriving one per request
//
//   channel  signals                         direction  carries
//   in       in_valid / in_stall             input      one vertex and query
//   out      out_valid / out_stall           output     minimum, segment flag
//
// a vertex that closes a segment runs the 16-bit fraction divider only when
// the projection does not land on an end point; a first vertex is only
// stored. the shared multiplier forms every product in turn. the result
// sits in an output register, so the next request is taken while it waits;
// a request that also ends a polyline holds the block until that result is taken.
// reset is synchronous and clears the sequencer, the previous vertex (to
// 0,0), the running minimum (to all ones) and the segment flag.
// ----------------------------------------------------------------------------
module point_polyline_distance_squared
  import ppds_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         first_vertex,
  input  logic                         last_vertex,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [DIST_BITS-1:0]         min_distance_sq,
  output logic                         segment_seen
);

  localparam int D      = COORD_BITS + 1;
  localparam int MW     = (COORD_BITS + 2 > FRACTION_BITS + 1) ?
                          COORD_BITS + 2 : FRACTION_BITS + 1;
  localparam int LEN_W  = 2 * COORD_BITS + 2;
  localparam int DOT_W  = 2 * COORD_BITS + 3;
  localparam int SUM_W  = 2 * COORD_BITS + 2;
  localparam int WIDE_W = (SUM_W > DIST_BITS) ? SUM_W : DIST_BITS;
  localparam int PR_W   = COORD_BITS + FRACTION_BITS + 2;
  localparam int R_W    = PR_W - FRACTION_BITS;
  localparam int PT_W   = COORD_BITS + 3;
  localparam logic [PR_W-1:0] HALF = PR_W'(1) << (FRACTION_BITS - 1);

  ppds_state_t state, state_next;

  logic signed [COORD_BITS-1:0] qx, qy, vx, vy;
  logic                         last;
  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic [DIST_BITS-1:0]         best;
  logic                         have_segment;

  logic signed [D-1:0]     dx, dy, wx, wy;
  logic [LEN_W-1:0]        len;
  logic signed [DOT_W-1:0] dot;
  logic [FRACTION_BITS-1:0] alpha;
  logic signed [D-1:0]     px, py;
  logic [SUM_W-1:0]        dsum;

  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [2*MW-1:0]  prod;

  logic                     div_start, div_busy;
  logic [FRACTION_BITS-1:0] div_q;

  logic signed [D:0]       adx, ady;
  logic signed [D-1:0]     ex, ey;
  logic [PR_W-1:0]         rsum;
  logic [R_W-1:0]          r;
  logic signed [PT_W-1:0]  pt_x, pt_y;
  logic                    dot_le0, dot_ge_len;
  logic [WIDE_W-1:0]       wide;
  logic [DIST_BITS-1:0]    sat;
  logic                    accept, out_free;

  ppds_mul #(.WIDTH(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ppds_div #(.NUM_BITS(LEN_W), .FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (dot[LEN_W-1:0]),
    .denom    (len),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    in_stall   = (state != S_IDLE);
    accept     = in_valid && !in_stall;
    out_free   = !out_valid || !out_stall;
    adx        = dx[D-1] ? -(D+1)'(dx) : (D+1)'(dx);
    ady        = dy[D-1] ? -(D+1)'(dy) : (D+1)'(dy);
    ex         = D'(qx) - px;
    ey         = D'(qy) - py;
    rsum       = prod[PR_W-1:0] + HALF;
    r          = rsum[PR_W-1:FRACTION_BITS];
    pt_x       = dx[D-1] ? PT_W'(prev_x) - $signed({1'b0, r})
                         : PT_W'(prev_x) + $signed({1'b0, r});
    pt_y       = dy[D-1] ? PT_W'(prev_y) - $signed({1'b0, r})
                         : PT_W'(prev_y) + $signed({1'b0, r});
    dot_le0    = dot[DOT_W-1] || (dot == '0);
    dot_ge_len = dot[LEN_W-1:0] >= len;
    wide       = WIDE_W'(dsum);
    sat        = (wide > WIDE_W'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}}
                                                     : wide[DIST_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = first_vertex ? S_FINISH : S_DIFF;
        end
      end
      S_DIFF:    state_next = S_LEN_X;
      S_LEN_X: begin
        mul_a      = MW'(dx);
        mul_b      = MW'(dx);
        state_next = S_LEN_Y;
      end
      S_LEN_Y: begin
        mul_a      = MW'(dy);
        mul_b      = MW'(dy);
        state_next = S_DOT_X;
      end
      S_DOT_X: begin
        mul_a      = MW'(wx);
        mul_b      = MW'(dx);
        state_next = S_DOT_Y;
      end
      S_DOT_Y: begin
        mul_a      = MW'(wy);
        mul_b      = MW'(dy);
        state_next = S_DOT_ADD;
      end
      S_DOT_ADD: state_next = S_CHOOSE;
      S_CHOOSE: begin
        if (len == '0 || dot_le0 || dot_ge_len) begin
          state_next = S_DIST_X;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_next = S_AX;
        end
      end
      S_AX: begin
        mul_a      = MW'(adx);
        mul_b      = MW'($signed({1'b0, alpha}));
        state_next = S_AY;
      end
      S_AY: begin
        mul_a      = MW'(ady);
        mul_b      = MW'($signed({1'b0, alpha}));
        state_next = S_PY;
      end
      S_PY:      state_next = S_DIST_X;
      S_DIST_X: begin
        mul_a      = MW'(ex);
        mul_b      = MW'(ex);
        state_next = S_DIST_Y;
      end
      S_DIST_Y: begin
        mul_a      = MW'(ey);
        mul_b      = MW'(ey);
        state_next = S_DIST_ADD;
      end
      S_DIST_ADD: state_next = S_UPDATE;
      S_UPDATE:   state_next = S_FINISH;
      S_FINISH: begin
        if (!last || out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // segment state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x       <= '0;
      prev_y       <= '0;
      best         <= {DIST_BITS{1'b1}};
      have_segment <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_FINISH && last && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept && first_vertex) begin
        best         <= {DIST_BITS{1'b1}};
        have_segment <= 1'b0;
      end
      if (state == S_UPDATE) begin
        if (sat < best) begin
          best <= sat;
        end
        have_segment <= 1'b1;
      end
      if (state == S_FINISH && (!last || out_free)) begin
        prev_x <= vx;
        prev_y <= vy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && last && out_free) begin
      min_distance_sq <= best;
      segment_seen    <= have_segment;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      qx   <= query_x;
      qy   <= query_y;
      vx   <= vertex_x;
      vy   <= vertex_y;
      last <= last_vertex;
    end
    unique case (state)
      S_DIFF: begin
        dx <= D'(vx) - D'(prev_x);
        dy <= D'(vy) - D'(prev_y);
        wx <= D'(qx) - D'(prev_x);
        wy <= D'(qy) - D'(prev_y);
      end
      S_LEN_Y:    len  <= prod[LEN_W-1:0];
      S_DOT_X:    len  <= len + prod[LEN_W-1:0];
      S_DOT_Y:    dot  <= $signed(prod[DOT_W-1:0]);
      S_DOT_ADD:  dot  <= dot + $signed(prod[DOT_W-1:0]);
      S_CHOOSE: begin
        if (len == '0 || dot_le0) begin
          px <= D'(prev_x);
          py <= D'(prev_y);
        end else if (dot_ge_len) begin
          px <= D'(vx);
          py <= D'(vy);
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          alpha <= div_q;
        end
      end
      S_AY:       px   <= pt_x[D-1:0];
      S_PY:       py   <= pt_y[D-1:0];
      S_DIST_Y:   dsum <= prod[SUM_W-1:0];
      S_DIST_ADD: dsum <= dsum + prod[SUM_W-1:0];
      default: begin
      end
    endcase
  end

endmodule

// ----- verif/point_polyline_distance_squared_test.sv -----
// ----------------------------------------------------------------------------
// point_polyline_distance_squared_test
// feeds polylines one vertex per request, with the query point on each, and
// checks every reported minimum squared distance and segment flag against a
// fixed-point projection model kept in the bench or a value pinned in the
// table. a short table of hand-made polylines comes first, then random
// polylines of mixed scale with some badly framed ones. the sender idles in
// bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module point_polyline_distance_squared_test;
  import ppds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;
  typedef logic [DIST_BITS-1:0] dist_t;

  typedef struct {
    coord_t qx;
    coord_t qy;
    coord_t vx;
    coord_t vy;
    bit     is_first;
    bit     is_last;
    bit     pinned;
    dist_t  dist_sq;
    bit     seen;
  } vertex_row_t;

  typedef struct {
    dist_t dist_sq;
    bit    seen;
  } polyline_result_t;

  typedef enum int {RX_STREAM, RX_SPARSE, RX_RUNS, RX_HEAVY} rx_mode_t;

  localparam int       FRAC        = FRACTION_BITS_DEF;
  localparam bit [63:0] DIST_CAP   = (64'd1 << DIST_BITS) - 1;
  localparam dist_t    DIST_NONE   = '1;
  localparam int       C_MAX       = 8388607;
  localparam int       C_MIN       = -8388608;
  localparam int       IDLE_LIMIT  = 5000;
  localparam int       TARGET      = 1650;

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  coord_t query_x;
  coord_t query_y;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   first_vertex;
  logic   last_vertex;
  logic   out_valid;
  logic   out_stall = 1'b0;
  dist_t  min_distance_sq;
  logic   segment_seen;

  point_polyline_distance_squared dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .query_x         (query_x),
    .query_y         (query_y),
    .vertex_x        (vertex_x),
    .vertex_y        (vertex_y),
    .first_vertex    (first_vertex),
    .last_vertex     (last_vertex),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .min_distance_sq (min_distance_sq),
    .segment_seen    (segment_seen)
  );

  longint           prev_vx = 0;
  longint           prev_vy = 0;
  dist_t            running_min = DIST_NONE;
  bit               segment_flag = 1'b0;
  polyline_result_t pending_minima[$];
  polyline_result_t head;
  vertex_row_t      directed_rows[$];

  int       vertices_sent = 0;
  int       polylines_sent = 0;
  int       results_checked = 0;
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;
  rx_mode_t stall_mode = RX_STREAM;
  int       stall_mode_left = 0;
  int       stall_run = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic dist_t squared_gap(longint ax, longint ay, longint bx, longint by);
    longint    ex;
    longint    ey;
    bit [63:0] sum;
    ex = ax - bx;
    ey = ay - by;
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    sum = ex * ex + ey * ey;
    return (sum > DIST_CAP) ? DIST_CAP[DIST_BITS-1:0] : sum[DIST_BITS-1:0];
  endfunction

  function automatic longint project_axis(longint s, longint d, longint alpha);
    longint mag;
    longint r;
    mag = ((d < 0) ? -d : d) * alpha;
    r = (mag + (longint'(1) << (FRAC - 1))) >>> FRAC;
    return (d < 0) ? s - r : s + r;
  endfunction

  function automatic dist_t segment_distance(longint qx, longint qy, longint sx,
                                             longint sy, longint ex, longint ey);
    longint    dx;
    longint    dy;
    longint    len;
    longint    dot;
    bit [63:0] rem;
    bit [63:0] div;
    bit [63:0] alpha;
    int        i;
    dx = ex - sx;
    dy = ey - sy;
    len = dx * dx + dy * dy;
    dot = (qx - sx) * dx + (qy - sy) * dy;
    if (len == 0 || dot <= 0) return squared_gap(qx, qy, sx, sy);
    if (dot >= len) return squared_gap(qx, qy, ex, ey);
    rem = dot;
    div = len;
    alpha = 0;
    for (i = 0; i < FRAC; i++) begin
      rem = rem << 1;
      alpha = alpha << 1;
      if (rem >= div) begin
        rem = rem - div;
        alpha = alpha | 64'd1;
      end
    end
    return squared_gap(qx, qy, project_axis(sx, dx, longint'(alpha)),
                       project_axis(sy, dy, longint'(alpha)));
  endfunction

  task automatic track_vertex(input vertex_row_t r);
    polyline_result_t res;
    dist_t            d;
    if (r.is_first) begin
      running_min = DIST_NONE;
      segment_flag = 1'b0;
    end else begin
      d = segment_distance(longint'(r.qx), longint'(r.qy), prev_vx, prev_vy,
                           longint'(r.vx), longint'(r.vy));
      if (d < running_min) running_min = d;
      segment_flag = 1'b1;
    end
    prev_vx = longint'(r.vx);
    prev_vy = longint'(r.vy);
    vertices_sent++;
    if (r.is_last) begin
      res.dist_sq = r.pinned ? r.dist_sq : running_min;
      res.seen = r.pinned ? r.seen : segment_flag;
      pending_minima.push_back(res);
      polylines_sent++;
    end
  endtask

  function automatic vertex_row_t make_row(int qx, int qy, int vx, int vy, bit f, bit l,
                                           bit pinned = 1'b0, dist_t dist_sq = '0,
                                           bit seen = 1'b0);
    vertex_row_t r;
    r.qx = coord_t'(qx);
    r.qy = coord_t'(qy);
    r.vx = coord_t'(vx);
    r.vy = coord_t'(vy);
    r.is_first = f;
    r.is_last = l;
    r.pinned = pinned;
    r.dist_sq = dist_sq;
    r.seen = seen;
    return r;
  endfunction

  function automatic coord_t pick_coord(int center, int spread);
    if (spread == 0) return coord_t'($urandom());
    return coord_t'(center + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // entered and left at a falling edge
  task automatic send_vertex(input vertex_row_t r);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    query_x = r.qx;
    query_y = r.qy;
    vertex_x = r.vx;
    vertex_y = r.vy;
    first_vertex = r.is_first;
    last_vertex = r.is_last;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_vertex(r);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_minima.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(50, 400);
    end
    stall_mode_left--;
    case (stall_mode)
      RX_STREAM: out_stall = 1'b0;
      RX_SPARSE: out_stall = ($urandom_range(0, 2) == 0);
      RX_RUNS: begin
        if (stall_run == 0) begin
          out_stall = ~out_stall;
          stall_run = $urandom_range(1, 12);
        end
        stall_run--;
      end
      default: out_stall = ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (pending_minima.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with none expected: dist %0d seen %0d",
                   results_checked, min_distance_sq, segment_seen);
      end else begin
        head = pending_minima.pop_front();
        if (min_distance_sq !== head.dist_sq) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d min_distance_sq: expected %0d, got %0d",
                     results_checked, head.dist_sq, min_distance_sq);
        end
        if (segment_seen !== head.seen) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d segment_seen: expected %0d, got %0d",
                     results_checked, head.seen, segment_seen);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("no progress for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_minima.size());
      $display("point_polyline_distance_squared: mismatch");
      $finish;
    end
  end

  initial begin
    vertex_row_t r;
    int          center;
    int          spread;
    int          nverts;
    bit          noisy;
    bit          paused;
    int          k;

    rst = 1'b1;
    in_valid = 1'b0;
    query_x = '0;
    query_y = '0;
    vertex_x = '0;
    vertex_y = '0;
    first_vertex = 1'b0;
    last_vertex = 1'b0;

    // open polyline from the reset origin, then single vertex, then continuation
    directed_rows.push_back(make_row(0, 0, 3, 4, 0, 1, 1, '0, 1));
    directed_rows.push_back(make_row(10, 0, 5, 5, 1, 1, 1, DIST_NONE, 0));
    directed_rows.push_back(make_row(5, 5, 5, 5, 0, 1, 1, '0, 1));
    // corner to opposite corner across a zero-length segment
    directed_rows.push_back(make_row(C_MAX, C_MAX, C_MIN, C_MIN, 1, 0));
    directed_rows.push_back(make_row(C_MAX, C_MAX, C_MIN, C_MIN, 0, 1, 1,
                                     dist_t'(50'd562949886312450), 1));
    directed_rows.push_back(make_row(C_MIN, C_MAX, C_MIN, C_MIN, 1, 0));
    directed_rows.push_back(make_row(C_MIN, C_MAX, C_MAX, C_MAX, 0, 0));
    directed_rows.push_back(make_row(C_MAX, C_MIN, C_MAX, C_MIN, 0, 1));
    // start clamp, end clamp, interior with negative direction
    directed_rows.push_back(make_row(-100, 50, 0, 0, 1, 0));
    directed_rows.push_back(make_row(-100, 50, 100, 0, 0, 0));
    directed_rows.push_back(make_row(300, 7, 200, 0, 0, 0));
    directed_rows.push_back(make_row(150, -3, 150, -300, 0, 0));
    directed_rows.push_back(make_row(7, -11, -1000, -5, 0, 0));
    directed_rows.push_back(make_row(7, -11, -1000, -5, 0, 1));
    // fraction rounding on a short segment
    directed_rows.push_back(make_row(1, 1, 0, 0, 1, 0));
    directed_rows.push_back(make_row(1, 1, 3, 1, 0, 0));
    directed_rows.push_back(make_row(1, 1, -3, 5, 0, 1));
    directed_rows.push_back(make_row(0, 0, C_MAX, C_MIN, 1, 0));
    directed_rows.push_back(make_row(C_MIN, C_MIN, C_MIN, C_MAX, 0, 1));
    // restart without closing, then a lone vertex
    directed_rows.push_back(make_row(0, 0, 1, 1, 1, 0));
    directed_rows.push_back(make_row(0, 0, 2, 2, 1, 1, 1, DIST_NONE, 0));
    directed_rows.push_back(make_row(-1, -1, -1, -1, 0, 0));
    directed_rows.push_back(make_row(C_MAX, 0, C_MIN, 0, 0, 1));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) send_vertex(directed_rows[i]);
    drain_results();

    paused = 1'b0;
    while (vertices_sent < TARGET) begin
      case ($urandom_range(0, 3))
        0: spread = 0;
        1: spread = 1 << 20;
        2: spread = 4096;
        default: spread = 16;
      endcase
      center = $urandom();
      nverts = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      noisy = ($urandom_range(0, 9) == 0);
      r = make_row(0, 0, 0, 0, 0, 0);
      r.qx = pick_coord(center, spread);
      r.qy = pick_coord(center, spread);
      for (k = 0; k < nverts; k++) begin
        if (k == 0 || $urandom_range(0, 7) != 0) begin
          r.vx = pick_coord(center, spread);
          r.vy = pick_coord(center, spread);
        end
        r.is_first = (k == 0);
        r.is_last = (k == nverts - 1);
        if (noisy) begin
          r.is_first = ($urandom_range(0, 3) == 0);
          r.is_last = ($urandom_range(0, 2) == 0);
          r.qx = pick_coord(center, spread);
          r.qy = pick_coord(center, spread);
        end
        send_vertex(r);
      end
      if (!paused && vertices_sent > TARGET / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("sent %0d vertices closing %0d polylines, checked %0d results",
             vertices_sent, polylines_sent, results_checked);
    $display("included origin start, lone vertices, zero-length and clamped segments");
    if (mismatch_count == 0)
      $display("point_polyline_distance_squared: match");
    else
      $display("point_polyline_distance_squared: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ppds_pkg.sv
rtl/core/ppds_mul.sv
rtl/core/ppds_div.sv
rtl/core/point_polyline_distance_squared.sv
verif/point_polyline_distance_squared_test.sv
